// ===== src/gqv_pkg.sv =====
// ----------------------------------------------------------------------------
// gqv_pkg
// Shared types and constants for the glyph quad vertex generator.
// ----------------------------------------------------------------------------
package gqv_pkg;

   localparam int TableDepth   = 256;
   localparam int IdxW         = $clog2(TableDepth);
   localparam int CntW         = IdxW + 1;
   localparam int EntryCountW  = 9;
   localparam int CodeW        = 21;
   localparam int ShapeW       = 34;
   localparam int AtlasW       = 24;
   localparam int AdvW         = 9;
   localparam int FracBits     = 16;
   localparam int Verts        = 6;
   localparam int ReqDataW     = 104;
   localparam int RspDataW     = 176;
   localparam logic [CodeW-1:0] NewlineCode = 21'd10;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_CHAR  = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X  = 3'd0,
      REG_ORIGIN_Y  = 3'd1,
      REG_LINE_SP   = 3'd2,
      REG_SCALE     = 3'd3,
      REG_COLOR     = 3'd4,
      REG_TOP_DOWN  = 3'd5,
      REG_ENTRIES   = 3'd6
   } reg_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;     // capture accepted request
      logic table_write;   // write table entry
      logic pen_begin;     // pen := origin
      logic newline;       // newline pen step
      logic search_init;   // start binary search
      logic probe_issue;   // read key at mid
      logic probe_eval;    // compare key
      logic entry_read;    // read entry data
      logic geom_calc;     // compute corner values stage 1
      logic geom_mul;      // multiply stage
      logic emit_vertex;   // load vertex into output reg
      logic emit_summary;  // load summary into output reg
      logic pen_advance;   // advance pen, count vertices
   } gqv_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type    command;
      logic       is_newline;
      logic       search_done;
      logic       out_busy;
      logic [2:0] corner;
   } gqv_status_type;

endpackage

// ===== src/gqv_ram.sv =====
// ----------------------------------------------------------------------------
// gqv_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gqv_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gqv_ctrl.sv =====
// ----------------------------------------------------------------------------
// gqv_ctrl
// Sequencer: decodes a request and steps search, geometry and emission.
// ----------------------------------------------------------------------------
module gqv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  gqv_pkg::gqv_status_type status,
   output gqv_pkg::gqv_cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DECODE  = 9'b000000010,
      ST_PROBE   = 9'b000000100,
      ST_WAIT    = 9'b000001000,
      ST_READ    = 9'b000010000,
      ST_GEOM    = 9'b000100000,
      ST_MUL     = 9'b001000000,
      ST_EMIT    = 9'b010000000,
      ST_SUMMARY = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.command)
               gqv_pkg::CMD_LOAD: begin
                  cmd.table_write = 1'b1;
                  state_in        = ST_IDLE;
               end
               gqv_pkg::CMD_BEGIN: begin
                  cmd.pen_begin = 1'b1;
                  state_in      = ST_IDLE;
               end
               gqv_pkg::CMD_END: begin
                  state_in = ST_SUMMARY;
               end
               default: begin
                  if (status.is_newline) begin
                     cmd.newline = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.search_init = 1'b1;
                     state_in        = ST_PROBE;
                  end
               end
            endcase
         end
         ST_PROBE: begin
            if (status.search_done) begin
               state_in = ST_READ;
            end else begin
               cmd.probe_issue = 1'b1;
               state_in        = ST_WAIT;
            end
         end
         // key at mid is on the read port now
         ST_WAIT: begin
            cmd.probe_eval = 1'b1;
            state_in       = ST_PROBE;
         end
         ST_READ: begin
            cmd.entry_read = 1'b1;
            state_in       = ST_GEOM;
         end
         ST_GEOM: begin
            cmd.geom_calc = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.geom_mul = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit_vertex = 1'b1;
               if (status.corner == 3'(gqv_pkg::Verts - 1)) begin
                  cmd.pen_advance = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_SUMMARY: begin
            if (!status.out_busy) begin
               cmd.emit_summary = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/gqv_datapath.sv =====
// ----------------------------------------------------------------------------
// gqv_datapath
// Registers, glyph table, search pointers, vertex math and output register.
// ----------------------------------------------------------------------------
module gqv_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [2:0]                          csr_index,
   input  logic [31:0]                         csr_data,
   input  logic [gqv_pkg::ReqDataW-1:0]        req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gqv_pkg::RspDataW-1:0]        rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  gqv_pkg::gqv_cmd_type                cmd,
   output gqv_pkg::gqv_status_type             status
);

   localparam int IdxW = gqv_pkg::IdxW;
   localparam int CntW = gqv_pkg::CntW;

   // configuration registers
   logic [31:0] origin_x_ff, origin_y_ff, color_ff;
   logic [30:0] line_sp_ff;
   logic [23:0] scale_ff;
   logic        top_down_ff;
   logic [8:0]  entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         line_sp_ff  <= 31'(32'd16 << gqv_pkg::FracBits);
         scale_ff    <= 24'(32'd1 << gqv_pkg::FracBits);
         color_ff    <= '1;
         top_down_ff <= 1'b0;
         entries_ff  <= 9'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            gqv_pkg::REG_ORIGIN_X: origin_x_ff <= csr_data;
            gqv_pkg::REG_ORIGIN_Y: origin_y_ff <= csr_data;
            gqv_pkg::REG_LINE_SP:  line_sp_ff  <= csr_data[30:0];
            gqv_pkg::REG_SCALE:    scale_ff    <= csr_data[23:0];
            gqv_pkg::REG_COLOR:    color_ff    <= csr_data;
            gqv_pkg::REG_TOP_DOWN: top_down_ff <= csr_data[0];
            gqv_pkg::REG_ENTRIES:  entries_ff  <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // captured request
   logic [gqv_pkg::ReqDataW-1:0] item_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_tdata;
   end

   logic [1:0]                   f_cmd;
   logic [gqv_pkg::CodeW-1:0]    f_code;
   logic [7:0]                   f_idx;
   assign f_cmd  = item_ff[1:0];
   assign f_code = item_ff[22:2];
   assign f_idx  = item_ff[30:23];

   // search pointers
   logic [CntW-1:0] lo_ff, hi_ff, mid_ff;
   logic [IdxW-1:0] found_ff;
   logic            hit_ff;
   logic [CntW:0]   mid_sum;
   logic [CntW-1:0] mid_val;
   logic [CntW-1:0] n_sat;

   assign n_sat   = (entries_ff > 9'(gqv_pkg::TableDepth))
                  ? CntW'(gqv_pkg::TableDepth) : CntW'(entries_ff);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_val = mid_sum[CntW:1];

   // table memories
   logic                       tbl_we;
   logic [IdxW-1:0]            rd_addr;
   logic [gqv_pkg::CodeW-1:0]  key_rd;
   logic [gqv_pkg::ShapeW-1:0] shape_rd;
   logic [gqv_pkg::AtlasW-1:0] atlas_rd;
   logic [gqv_pkg::AdvW-1:0]   adv_rd;

   assign tbl_we  = cmd.table_write;
   assign rd_addr = cmd.probe_issue ? mid_val[IdxW-1:0] : found_ff;

   gqv_ram #(.Width(gqv_pkg::CodeW), .Depth(gqv_pkg::TableDepth)) u_key (
      .clock, .wr_en(tbl_we), .wr_addr(f_idx), .wr_data(f_code),
      .rd_addr, .rd_data(key_rd));
   gqv_ram #(.Width(gqv_pkg::ShapeW), .Depth(gqv_pkg::TableDepth)) u_shape (
      .clock, .wr_en(tbl_we), .wr_addr(f_idx), .wr_data(item_ff[64:31]),
      .rd_addr, .rd_data(shape_rd));
   gqv_ram #(.Width(gqv_pkg::AtlasW), .Depth(gqv_pkg::TableDepth)) u_atlas (
      .clock, .wr_en(tbl_we), .wr_addr(f_idx), .wr_data(item_ff[88:65]),
      .rd_addr, .rd_data(atlas_rd));
   gqv_ram #(.Width(gqv_pkg::AdvW), .Depth(gqv_pkg::TableDepth)) u_adv (
      .clock, .wr_en(tbl_we), .wr_addr(f_idx), .wr_data(item_ff[97:89]),
      .rd_addr, .rd_data(adv_rd));

   // binary search steps
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         lo_ff    <= '0;
         hi_ff    <= n_sat;
         found_ff <= '0;
         hit_ff   <= 1'b0;
      end else if (cmd.probe_issue) begin
         mid_ff <= mid_val;
      end else if (cmd.probe_eval) begin
         if (key_rd == f_code) begin
            found_ff <= mid_ff[IdxW-1:0];
            hit_ff   <= 1'b1;
         end else if (key_rd < f_code) begin
            lo_ff <= mid_ff + 1'b1;
         end else begin
            hi_ff <= mid_ff;
         end
      end
   end

   // geometry: sums, then products
   logic [31:0] left_s, top_s, sum_xr, sum_yb;
   logic [7:0]  w_v, h_v;
   logic [31:0] xl_ff, xr_ff, yt_ff, yb_ff, adv_ff;
   logic [31:0] ml_ff, mr_ff, mt_ff, mb_ff, ma_ff;
   logic [12:0] s0_ff, s1_ff, t0_ff, t1_ff;

   assign left_s = {{23{shape_rd[8]}}, shape_rd[8:0]};
   assign top_s  = {{23{shape_rd[17]}}, shape_rd[17:9]};
   assign w_v    = shape_rd[25:18];
   assign h_v    = shape_rd[33:26];
   assign sum_xr = left_s + {24'd0, w_v};
   assign sum_yb = top_s - {24'd0, h_v};

   always_ff @(posedge clock) begin
      if (cmd.geom_calc) begin
         ml_ff <= left_s;
         mr_ff <= sum_xr;
         mt_ff <= top_s;
         mb_ff <= sum_yb;
         ma_ff <= {23'd0, adv_rd};
         s0_ff <= {1'b0, atlas_rd[11:0]};
         s1_ff <= 13'({1'b0, atlas_rd[11:0]} + {5'd0, w_v});
         t0_ff <= {1'b0, atlas_rd[23:12]};
         t1_ff <= 13'({1'b0, atlas_rd[23:12]} + {5'd0, h_v});
      end
      if (cmd.geom_mul) begin
         xl_ff  <= 32'(ml_ff * {8'd0, scale_ff});
         xr_ff  <= 32'(mr_ff * {8'd0, scale_ff});
         yt_ff  <= 32'(mt_ff * {8'd0, scale_ff});
         yb_ff  <= 32'(mb_ff * {8'd0, scale_ff});
         adv_ff <= 32'(ma_ff * {8'd0, scale_ff});
      end
   end

   // corner selection
   logic [2:0]  corner_ff;
   logic [31:0] vx, vy, rx, ry;
   logic [12:0] vs, vt;

   always_comb begin
      case (corner_ff)
         3'd0, 3'd1: begin vx = xl_ff; vy = yt_ff; vs = s0_ff; vt = t0_ff; end
         3'd2:       begin vx = xl_ff; vy = yb_ff; vs = s0_ff; vt = t1_ff; end
         3'd3:       begin vx = xr_ff; vy = yt_ff; vs = s1_ff; vt = t0_ff; end
         default:    begin vx = xr_ff; vy = yb_ff; vs = s1_ff; vt = t1_ff; end
      endcase
      if (top_down_ff) begin
         rx = vy;
         ry = 32'd0 - vx;
      end else begin
         rx = vx;
         ry = vy;
      end
   end

   // pen and vertex count
   logic [31:0] pen_x_ff, pen_y_ff;
   logic [15:0] count_ff;
   logic [16:0] count_sum;
   assign count_sum = {1'b0, count_ff} + 17'(gqv_pkg::Verts);

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff  <= '0;
         pen_y_ff  <= '0;
         count_ff  <= '0;
         corner_ff <= '0;
      end else begin
         if (cmd.geom_mul) corner_ff <= '0;
         else if (cmd.emit_vertex) corner_ff <= corner_ff + 3'd1;
         if (cmd.pen_begin) begin
            pen_x_ff <= origin_x_ff;
            pen_y_ff <= origin_y_ff;
            count_ff <= '0;
         end else if (cmd.newline) begin
            if (top_down_ff) begin
               pen_x_ff <= pen_x_ff - {1'b0, line_sp_ff};
               pen_y_ff <= origin_y_ff;
            end else begin
               pen_x_ff <= origin_x_ff;
               pen_y_ff <= pen_y_ff - {1'b0, line_sp_ff};
            end
         end else if (cmd.pen_advance) begin
            if (top_down_ff) pen_y_ff <= pen_y_ff - adv_ff;
            else             pen_x_ff <= pen_x_ff + adv_ff;
            count_ff <= count_sum[16] ? 16'hFFFF : count_sum[15:0];
         end
      end
   end

   // output register
   logic                         out_valid_ff;
   logic [gqv_pkg::RspDataW-1:0] out_data_ff;
   logic                         out_kind_ff, out_last_ff;
   logic [31:0]                  ext;

   assign ext = top_down_ff ? (origin_y_ff - pen_y_ff) : (pen_x_ff - origin_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_vertex || cmd.emit_summary) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // vertex fields packed back to back from bit 0, zero fill on top; summary fields sit above 125 zero bits
   always_ff @(posedge clock) begin
      if (cmd.emit_vertex) begin
         out_kind_ff <= 1'b0;
         out_last_ff <= (corner_ff == 3'(gqv_pkg::Verts - 1));
         out_data_ff <= {51'd0, corner_ff, color_ff, vt, vs,
                         ry + pen_y_ff, rx + pen_x_ff};
      end else if (cmd.emit_summary) begin
         out_kind_ff <= 1'b1;
         out_last_ff <= 1'b1;
         out_data_ff <= {3'd0, count_ff, ext, 125'd0};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   assign status.command     = gqv_pkg::cmd_type'(f_cmd);
   assign status.is_newline  = (f_code == gqv_pkg::NewlineCode);
   assign status.search_done = hit_ff || !(lo_ff < hi_ff);
   assign status.out_busy    = out_valid_ff && !rsp_tready;
   assign status.corner      = corner_ff;

endmodule

// ===== src/glyph_quad_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_vertex_generator
// Lays out text as textured quads from a sorted, searchable glyph table.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | tdata: command, char_code, entry_index, glyph_left, glyph_top,
//         |     |        glyph_width, glyph_height, atlas_s, atlas_t, glyph_advance
// rsp     | out | tdata: pos_x, pos_y, tex_s, tex_t, vertex_color, corner,
//         |     |        extent, vertex_total; tuser: kind; tlast: last
// csr     | in  | index 0..6, 32-bit data
// load, begin and newline return to idle after decode; end also waits for the output register.
// character: a binary search of at most 9 probes over 256 entries, then entry read,
// geometry and 6 vertex beats; each probe waits on the registered table read.
// reset clears pen and count and sets registers to their defaults; the table holds garbage until loaded.
// a stalled rsp beat holds the sequencer; req is taken only when idle.
module glyph_quad_vertex_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [1:0] command, [22:2] char_code, [30:23] entry_index, [39:31] glyph_left,
   // [48:40] glyph_top, [56:49] glyph_width, [64:57] glyph_height,
   // [76:65] atlas_s, [88:77] atlas_t, [97:89] glyph_advance
   input  logic [gqv_pkg::ReqDataW-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] pos_x, [63:32] pos_y, [76:64] tex_s, [89:77] tex_t,
   // [121:90] vertex_color, [124:122] corner, [156:125] extent,
   // [172:157] vertex_total, [175:173] zero pad
   output logic [gqv_pkg::RspDataW-1:0]  rsp_tdata,
   // [0] kind
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_data
);

   gqv_pkg::gqv_cmd_type    cmd;
   gqv_pkg::gqv_status_type status;

   assign csr_ready = 1'b1;

   gqv_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .status, .cmd);

   gqv_datapath u_dp (
      .clock, .reset, .csr_valid, .csr_index, .csr_data, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .cmd, .status);

endmodule

// ===== src/gqv_checker.sv =====
// ----------------------------------------------------------------------------
// gqv_checker
// Port-level checks for the glyph quad vertex generator.
// ----------------------------------------------------------------------------
module gqv_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [gqv_pkg::RspDataW-1:0] rsp_tdata,
   input logic                         rsp_tuser,
   input logic                         rsp_tlast
);

   // a stalled beat holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp payload changed under stall");

   // summaries always close their run
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("summary without last");

   // vertex beats are last only at corner five
   a_corner_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tlast == (rsp_tdata[124:122] == 3'd5)))
      else $error("last does not match corner");

   // no new request is taken while a non-last vertex beat waits
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("request taken mid glyph");

endmodule

bind glyph_quad_vertex_generator gqv_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser, .rsp_tlast);
